// File: sv/cfr_pkg.sv
// ----------------------------------------------------------------------------
// cfr_pkg
// shared types and constants of the framed receiver with resync
// ----------------------------------------------------------------------------
package cfr_pkg;

    localparam int BUFFER_BYTES = 33;
    localparam int ADDR_W       = $clog2(BUFFER_BYTES);
    localparam int CNT_W        = $clog2(BUFFER_BYTES + 1);
    localparam int CMP_W        = (CNT_W > 6) ? CNT_W : 6;

    localparam logic [15:0] CRC_POLY  = 16'hA001;
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam int          MIN_FRAME = 6;

    localparam logic [1:0] CFG_START   = 2'd0;
    localparam logic [1:0] CFG_MAXLEN  = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT = 2'd2;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_TAKE,
        OP_RS_START1,
        OP_RS_RD,
        OP_RS_EMPTY,
        OP_RS_NEXT,
        OP_RS_HIT,
        OP_CP_RD,
        OP_CP_WR,
        OP_RC_START,
        OP_RC_RD,
        OP_RC_UPD,
        OP_EM_START,
        OP_EM_RD,
        OP_EM_PUT,
        OP_EM_ZERO,
        OP_EM_END_CLR,
        OP_EM_END_RS,
        OP_FLUSH
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic is_tick;
        logic drop;
        logic over_lim;
        logic fill_lt_min;
        logic bad_len;
        logic len_eq_fill;
        logic len_lt_fill;
        logic frame_ok;
        logic calc_ok;
        logic scan_more;
        logic scan_hit;
        logic copy_more;
        logic rc_more;
        logic em_more;
        logic plen_zero;
        logic slot_ok;
        logic pend_valid;
        logic out_free;
    } dp_status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_POST_WR,
        ST_CHECK,
        ST_RS_RD,
        ST_RS_CHK,
        ST_CP_RD,
        ST_CP_WR,
        ST_RC_RD,
        ST_RC_UPD,
        ST_RC_END,
        ST_EM_INIT,
        ST_EM_RD,
        ST_EM_PUT,
        ST_EM_ZERO,
        ST_EM_END,
        ST_FINISH
    } state_t;

endpackage

// File: sv/cfr_ram.sv
// ----------------------------------------------------------------------------
// cfr_ram
// generic single write, single read ram with registered read
// ----------------------------------------------------------------------------
module cfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 33
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: sv/cfr_datapath.sv
// ----------------------------------------------------------------------------
// cfr_datapath
// frame buffer, crc, counters, config registers and result staging
// ----------------------------------------------------------------------------
module cfr_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  cfr_pkg::dp_cmd_t    cmd,
    output cfr_pkg::dp_status_t status,
    input  logic                operation,
    input  logic [7:0]          data_byte,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [7:0]          command,
    output logic [7:0]          payload_byte,
    output logic                has_payload,
    output logic                last
);

    localparam int CW = cfr_pkg::CNT_W;
    localparam int AW = cfr_pkg::ADDR_W;

    function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {8'h00, b};
        for (int n = 0; n < 8; n++)
        begin
            r = r[0] ? ((r >> 1) ^ cfr_pkg::CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

    logic [7:0]  start_reg, start_next;
    logic [5:0]  maxlen_reg, maxlen_next;
    logic [15:0] timeout_reg, timeout_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [15:0] crc_reg, crc_next;
    logic [15:0] idle_reg, idle_next;
    logic        pend_valid_reg, pend_valid_next;
    logic        out_valid_reg, out_valid_next;

    logic [15:0] calc_reg, calc_next;
    logic [CW-1:0] scan_reg, scan_next;
    logic [CW-1:0] src_reg, src_next;
    logic [CW-1:0] dst_reg, dst_next;
    logic [CW-1:0] k_reg, k_next;
    logic [7:0]  len_lo_reg, len_lo_next;
    logic [7:0]  len_hi_reg, len_hi_next;
    logic [7:0]  cmd_byte_reg, cmd_byte_next;
    logic [7:0]  pend_cmd_reg, pend_cmd_next;
    logic [7:0]  pend_pb_reg, pend_pb_next;
    logic        pend_has_reg, pend_has_next;
    logic [7:0]  out_cmd_reg, out_cmd_next;
    logic [7:0]  out_pb_reg, out_pb_next;
    logic        out_has_reg, out_has_next;
    logic        out_last_reg, out_last_next;

    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]    ram_wdata, ram_rdata;

    logic [cfr_pkg::CMP_W-1:0] lim;
    logic [15:0] len, plen;
    logic        put;
    logic [7:0]  put_pb;
    logic        put_has;
    logic        out_free;

    cfr_ram #(
        .WIDTH (8),
        .DEPTH (cfr_pkg::BUFFER_BYTES)
    ) u_buf (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        if (cfr_pkg::CMP_W'(maxlen_reg) > cfr_pkg::CMP_W'(cfr_pkg::BUFFER_BYTES - 1))
        begin
            lim = cfr_pkg::CMP_W'(cfr_pkg::BUFFER_BYTES - 1);
        end
        else
        begin
            lim = cfr_pkg::CMP_W'(maxlen_reg);
        end
    end

    assign len      = {len_hi_reg, len_lo_reg};
    assign plen     = len - 16'(cfr_pkg::MIN_FRAME);
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        status.is_tick     = operation;
        status.drop        = !operation && (fill_reg == '0) && (data_byte != start_reg);
        status.over_lim    = cfr_pkg::CMP_W'(fill_reg) > lim;
        status.fill_lt_min = fill_reg < CW'(cfr_pkg::MIN_FRAME);
        status.bad_len     = (len > 16'(lim)) || (len < 16'(cfr_pkg::MIN_FRAME));
        status.len_eq_fill = len == 16'(fill_reg);
        status.len_lt_fill = len < 16'(fill_reg);
        status.frame_ok    = (crc_reg == 16'h0000) && (cmd_byte_reg[5:0] == 6'd0);
        status.calc_ok     = (calc_reg == 16'h0000) && (cmd_byte_reg[5:0] == 6'd0);
        status.scan_more   = scan_reg < fill_reg;
        status.scan_hit    = ram_rdata == start_reg;
        status.copy_more   = dst_reg < fill_reg;
        status.rc_more     = 16'(k_reg) < len;
        status.em_more     = 16'(k_reg) < plen;
        status.plen_zero   = plen == 16'h0000;
        status.slot_ok     = !pend_valid_reg || out_free;
        status.pend_valid  = pend_valid_reg;
        status.out_free    = out_free;
    end

    always_comb
    begin
        start_next      = start_reg;
        maxlen_next     = maxlen_reg;
        timeout_next    = timeout_reg;
        fill_next       = fill_reg;
        crc_next        = crc_reg;
        idle_next       = idle_reg;
        pend_valid_next = pend_valid_reg;
        out_valid_next  = out_valid_reg;
        calc_next       = calc_reg;
        scan_next       = scan_reg;
        src_next        = src_reg;
        dst_next        = dst_reg;
        k_next          = k_reg;
        len_lo_next     = len_lo_reg;
        len_hi_next     = len_hi_reg;
        cmd_byte_next   = cmd_byte_reg;
        pend_cmd_next   = pend_cmd_reg;
        pend_pb_next    = pend_pb_reg;
        pend_has_next   = pend_has_reg;
        out_cmd_next    = out_cmd_reg;
        out_pb_next     = out_pb_reg;
        out_has_next    = out_has_reg;
        out_last_next   = out_last_reg;
        ram_we          = 1'b0;
        ram_waddr       = fill_reg[AW-1:0];
        ram_wdata       = data_byte;
        ram_re          = 1'b0;
        ram_raddr       = scan_reg[AW-1:0];
        put             = 1'b0;
        put_pb          = 8'h00;
        put_has         = 1'b0;

        if (cfg_we)
        begin
            case (cfg_index)
                cfr_pkg::CFG_START:   start_next   = cfg_data[7:0];
                cfr_pkg::CFG_MAXLEN:  maxlen_next  = cfg_data[5:0];
                cfr_pkg::CFG_TIMEOUT: timeout_next = cfg_data;
                default: ;
            endcase
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (cmd.op)
            cfr_pkg::OP_TAKE:
            begin
                if (operation)
                begin
                    if (idle_reg >= timeout_reg)
                    begin
                        fill_next = '0;
                        crc_next  = cfr_pkg::CRC_INIT;
                        idle_next = 16'h0000;
                    end
                    else
                    begin
                        idle_next = idle_reg + 16'd1;
                    end
                end
                else if (!status.drop)
                begin
                    ram_we    = 1'b1;
                    fill_next = fill_reg + CW'(1);
                    crc_next  = crc_step(crc_reg, data_byte);
                end
            end
            cfr_pkg::OP_RS_START1:
            begin
                crc_next  = cfr_pkg::CRC_INIT;
                scan_next = CW'(1);
            end
            cfr_pkg::OP_RS_RD:
            begin
                ram_re    = 1'b1;
                ram_raddr = scan_reg[AW-1:0];
            end
            cfr_pkg::OP_RS_EMPTY:
            begin
                fill_next = '0;
            end
            cfr_pkg::OP_RS_NEXT:
            begin
                scan_next = scan_reg + CW'(1);
            end
            cfr_pkg::OP_RS_HIT:
            begin
                fill_next = fill_reg - scan_reg;
                dst_next  = '0;
                src_next  = scan_reg;
            end
            cfr_pkg::OP_CP_RD:
            begin
                ram_re    = 1'b1;
                ram_raddr = src_reg[AW-1:0];
            end
            cfr_pkg::OP_CP_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = dst_reg[AW-1:0];
                ram_wdata = ram_rdata;
                crc_next  = crc_step(crc_reg, ram_rdata);
                dst_next  = dst_reg + CW'(1);
                src_next  = src_reg + CW'(1);
            end
            cfr_pkg::OP_RC_START:
            begin
                k_next    = '0;
                calc_next = cfr_pkg::CRC_INIT;
            end
            cfr_pkg::OP_RC_RD:
            begin
                ram_re    = 1'b1;
                ram_raddr = k_reg[AW-1:0];
            end
            cfr_pkg::OP_RC_UPD:
            begin
                calc_next = crc_step(calc_reg, ram_rdata);
                k_next    = k_reg + CW'(1);
            end
            cfr_pkg::OP_EM_START:
            begin
                k_next = '0;
            end
            cfr_pkg::OP_EM_RD:
            begin
                ram_re    = 1'b1;
                ram_raddr = AW'(k_reg + CW'(4));
            end
            cfr_pkg::OP_EM_PUT:
            begin
                put     = 1'b1;
                put_pb  = ram_rdata;
                put_has = 1'b1;
                k_next  = k_reg + CW'(1);
            end
            cfr_pkg::OP_EM_ZERO:
            begin
                put = 1'b1;
            end
            cfr_pkg::OP_EM_END_CLR:
            begin
                idle_next = 16'h0000;
                fill_next = '0;
                crc_next  = cfr_pkg::CRC_INIT;
            end
            cfr_pkg::OP_EM_END_RS:
            begin
                idle_next = 16'h0000;
                crc_next  = cfr_pkg::CRC_INIT;
                scan_next = len[CW-1:0];
            end
            cfr_pkg::OP_FLUSH:
            begin
                out_valid_next  = 1'b1;
                out_cmd_next    = pend_cmd_reg;
                out_pb_next     = pend_pb_reg;
                out_has_next    = pend_has_reg;
                out_last_next   = 1'b1;
                pend_valid_next = 1'b0;
            end
            default: ;
        endcase

        // header shadows follow buffer positions one to three
        if (ram_we)
        begin
            if (ram_waddr == AW'(1))
            begin
                len_lo_next = ram_wdata;
            end
            if (ram_waddr == AW'(2))
            begin
                len_hi_next = ram_wdata;
            end
            if (ram_waddr == AW'(3))
            begin
                cmd_byte_next = ram_wdata;
            end
        end

        // one word held back so that the final one can carry last
        if (put)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_cmd_next   = pend_cmd_reg;
                out_pb_next    = pend_pb_reg;
                out_has_next   = pend_has_reg;
                out_last_next  = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_cmd_next   = cmd_byte_reg;
            pend_pb_next    = put_pb;
            pend_has_next   = put_has;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg      <= 8'd85;
            maxlen_reg     <= 6'd32;
            timeout_reg    <= 16'd5000;
            fill_reg       <= '0;
            crc_reg        <= cfr_pkg::CRC_INIT;
            idle_reg       <= 16'h0000;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            start_reg      <= start_next;
            maxlen_reg     <= maxlen_next;
            timeout_reg    <= timeout_next;
            fill_reg       <= fill_next;
            crc_reg        <= crc_next;
            idle_reg       <= idle_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        calc_reg     <= calc_next;
        scan_reg     <= scan_next;
        src_reg      <= src_next;
        dst_reg      <= dst_next;
        k_reg        <= k_next;
        len_lo_reg   <= len_lo_next;
        len_hi_reg   <= len_hi_next;
        cmd_byte_reg <= cmd_byte_next;
        pend_cmd_reg <= pend_cmd_next;
        pend_pb_reg  <= pend_pb_next;
        pend_has_reg <= pend_has_next;
        out_cmd_reg  <= out_cmd_next;
        out_pb_reg   <= out_pb_next;
        out_has_reg  <= out_has_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid    = out_valid_reg;
    assign command      = out_cmd_reg;
    assign payload_byte = out_pb_reg;
    assign has_payload  = out_has_reg;
    assign last         = out_last_reg;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(cfr_pkg::BUFFER_BYTES))
        else $error("fill count beyond buffer depth");

    a_put_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == cfr_pkg::OP_EM_PUT || cmd.op == cfr_pkg::OP_EM_ZERO) |-> status.slot_ok)
        else $error("result produced with no free slot");

    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == cfr_pkg::OP_FLUSH) |=> (!pend_valid_reg && out_valid_reg && out_last_reg))
        else $error("flush did not move held word to output");

    a_flush_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == cfr_pkg::OP_FLUSH) |-> (out_free && pend_valid_reg))
        else $error("flush while output busy or nothing held");
`endif

endmodule

// File: sv/cfr_ctrl.sv
// ----------------------------------------------------------------------------
// cfr_ctrl
// sequencer for byte intake, rescan, crc recompute and payload emission
// ----------------------------------------------------------------------------
module cfr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  cfr_pkg::dp_status_t status,
    output cfr_pkg::dp_cmd_t    cmd
);

    cfr_pkg::state_t state_reg, state_next;
    logic after_clr_reg, after_clr_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cfr_pkg::ST_IDLE;
            after_clr_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            after_clr_reg <= after_clr_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        after_clr_next = after_clr_reg;
        cmd.op         = cfr_pkg::OP_NONE;
        in_stall       = 1'b1;

        case (state_reg)
            cfr_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.op = cfr_pkg::OP_TAKE;
                    if (!status.is_tick && !status.drop)
                    begin
                        state_next = cfr_pkg::ST_POST_WR;
                    end
                end
            end
            cfr_pkg::ST_POST_WR:
            begin
                if (status.over_lim)
                begin
                    cmd.op     = cfr_pkg::OP_RS_START1;
                    state_next = cfr_pkg::ST_RS_RD;
                end
                else
                begin
                    state_next = cfr_pkg::ST_CHECK;
                end
            end
            cfr_pkg::ST_CHECK:
            begin
                if (status.fill_lt_min)
                begin
                    state_next = cfr_pkg::ST_FINISH;
                end
                else if (status.bad_len)
                begin
                    cmd.op     = cfr_pkg::OP_RS_START1;
                    state_next = cfr_pkg::ST_RS_RD;
                end
                else if (status.len_eq_fill)
                begin
                    if (status.frame_ok)
                    begin
                        after_clr_next = 1'b1;
                        state_next     = cfr_pkg::ST_EM_INIT;
                    end
                    else
                    begin
                        cmd.op     = cfr_pkg::OP_RS_START1;
                        state_next = cfr_pkg::ST_RS_RD;
                    end
                end
                else if (status.len_lt_fill)
                begin
                    cmd.op     = cfr_pkg::OP_RC_START;
                    state_next = cfr_pkg::ST_RC_RD;
                end
                else
                begin
                    state_next = cfr_pkg::ST_FINISH;
                end
            end
            cfr_pkg::ST_RS_RD:
            begin
                if (status.scan_more)
                begin
                    cmd.op     = cfr_pkg::OP_RS_RD;
                    state_next = cfr_pkg::ST_RS_CHK;
                end
                else
                begin
                    cmd.op     = cfr_pkg::OP_RS_EMPTY;
                    state_next = cfr_pkg::ST_CHECK;
                end
            end
            cfr_pkg::ST_RS_CHK:
            begin
                if (status.scan_hit)
                begin
                    cmd.op     = cfr_pkg::OP_RS_HIT;
                    state_next = cfr_pkg::ST_CP_RD;
                end
                else
                begin
                    cmd.op     = cfr_pkg::OP_RS_NEXT;
                    state_next = cfr_pkg::ST_RS_RD;
                end
            end
            cfr_pkg::ST_CP_RD:
            begin
                if (status.copy_more)
                begin
                    cmd.op     = cfr_pkg::OP_CP_RD;
                    state_next = cfr_pkg::ST_CP_WR;
                end
                else
                begin
                    state_next = cfr_pkg::ST_CHECK;
                end
            end
            cfr_pkg::ST_CP_WR:
            begin
                cmd.op     = cfr_pkg::OP_CP_WR;
                state_next = cfr_pkg::ST_CP_RD;
            end
            cfr_pkg::ST_RC_RD:
            begin
                if (status.rc_more)
                begin
                    cmd.op     = cfr_pkg::OP_RC_RD;
                    state_next = cfr_pkg::ST_RC_UPD;
                end
                else
                begin
                    state_next = cfr_pkg::ST_RC_END;
                end
            end
            cfr_pkg::ST_RC_UPD:
            begin
                cmd.op     = cfr_pkg::OP_RC_UPD;
                state_next = cfr_pkg::ST_RC_RD;
            end
            cfr_pkg::ST_RC_END:
            begin
                if (status.calc_ok)
                begin
                    after_clr_next = 1'b0;
                    state_next     = cfr_pkg::ST_EM_INIT;
                end
                else
                begin
                    cmd.op     = cfr_pkg::OP_RS_START1;
                    state_next = cfr_pkg::ST_RS_RD;
                end
            end
            cfr_pkg::ST_EM_INIT:
            begin
                cmd.op     = cfr_pkg::OP_EM_START;
                state_next = status.plen_zero ? cfr_pkg::ST_EM_ZERO : cfr_pkg::ST_EM_RD;
            end
            cfr_pkg::ST_EM_RD:
            begin
                if (status.em_more)
                begin
                    cmd.op     = cfr_pkg::OP_EM_RD;
                    state_next = cfr_pkg::ST_EM_PUT;
                end
                else
                begin
                    state_next = cfr_pkg::ST_EM_END;
                end
            end
            cfr_pkg::ST_EM_PUT:
            begin
                if (status.slot_ok)
                begin
                    cmd.op     = cfr_pkg::OP_EM_PUT;
                    state_next = cfr_pkg::ST_EM_RD;
                end
            end
            cfr_pkg::ST_EM_ZERO:
            begin
                if (status.slot_ok)
                begin
                    cmd.op     = cfr_pkg::OP_EM_ZERO;
                    state_next = cfr_pkg::ST_EM_END;
                end
            end
            cfr_pkg::ST_EM_END:
            begin
                if (after_clr_reg)
                begin
                    cmd.op     = cfr_pkg::OP_EM_END_CLR;
                    state_next = cfr_pkg::ST_FINISH;
                end
                else
                begin
                    cmd.op     = cfr_pkg::OP_EM_END_RS;
                    state_next = cfr_pkg::ST_RS_RD;
                end
            end
            cfr_pkg::ST_FINISH:
            begin
                if (!status.pend_valid)
                begin
                    state_next = cfr_pkg::ST_IDLE;
                end
                else if (status.out_free)
                begin
                    cmd.op     = cfr_pkg::OP_FLUSH;
                    state_next = cfr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cfr_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: sv/crc16_frame_receiver_resync.sv
// ----------------------------------------------------------------------------
// crc16_frame_receiver_resync
// framed byte receiver with crc-16 check, resync by rescan and idle timeout
// ----------------------------------------------------------------------------
// channel  dir  handshake            fields
// in       in   in_valid/in_stall    operation, data_byte
// out      out  out_valid/out_stall  command, payload_byte, has_payload, last
// cfg      in   cfg_we               cfg_index, cfg_data
//
// a tick or dropped byte is handled in idle alone; a buffered byte passes post-write, check and finish
// a rescan reads and checks each scanned position and reads then writes each moved byte,
// a crc recompute reads and updates per byte and emission reads and puts each payload word
// one item at a time; the next is taken once the last word is staged
// output stalls hold the sequencer only when a second word is ready
// reset clears the count and crc at once; the buffer is never cleared
// ----------------------------------------------------------------------------
module crc16_frame_receiver_resync (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        operation,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  command,
    output logic [7:0]  payload_byte,
    output logic        has_payload,
    output logic        last,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    cfr_pkg::dp_cmd_t    cmd;
    cfr_pkg::dp_status_t status;

    cfr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    cfr_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .operation    (operation),
        .data_byte    (data_byte),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .command      (command),
        .payload_byte (payload_byte),
        .has_payload  (has_payload),
        .last         (last)
    );

endmodule
